// ===== sv/ukot_pkg.sv =====
// ----------------------------------------------------------------------------
// ukot_pkg
// Shared types and codes for the unique-key ordered table: request and status
// codes, the stored record layout and the memory control group.
// ----------------------------------------------------------------------------
`default_nettype none

package ukot_pkg;

    localparam int DEPTH_DEF = 128;

    // Request codes; code 3 is unused and answers with an empty OK.
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_FIND   = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_DUP  = 2'd2;
    localparam logic [1:0] ST_MISS = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT
    } state_t;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] value;
    } entry_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

endpackage

`default_nettype wire

// ===== sv/ukot_store.sv =====
// ----------------------------------------------------------------------------
// ukot_store
// Record memory: one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ukot_store #(
    parameter int DEPTH = ukot_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic               clk,
    input  wire ukot_pkg::mem_ctl_t ctl,
    input  wire logic [AW-1:0]      rd_addr,
    input  wire logic [AW-1:0]      wr_addr,
    input  wire ukot_pkg::entry_t   wr_data,
    output ukot_pkg::entry_t        rd_data
);
    import ukot_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== sv/ukot_ctrl.sv =====
// ----------------------------------------------------------------------------
// ukot_ctrl
// Sequencer for the ordered table: linear key scan through the record memory
// with a single key comparator, append on insert, shift-down on remove, and
// the registered result port.
// ----------------------------------------------------------------------------
`default_nettype none

module ukot_ctrl #(
    parameter int DEPTH = ukot_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         req_type,
    input  wire logic signed [31:0] key,
    input  wire logic [31:0]        record_value,
    output ukot_pkg::mem_ctl_t      mem_ctl,
    output logic [AW-1:0]           rd_addr,
    output logic [AW-1:0]           wr_addr,
    output ukot_pkg::entry_t        wr_data,
    input  wire ukot_pkg::entry_t   rd_data,
    output logic                    done,
    output logic [1:0]              status,
    output logic [6:0]              position,
    output logic [31:0]             found_value,
    output logic [7:0]              entry_count
);
    import ukot_pkg::*;

    state_t        state_reg, state_next;
    logic [1:0]    req_reg, req_next;
    logic [31:0]   key_reg, key_next;
    logic [31:0]   val_reg, val_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          pend_reg, pend_next;
    logic [AW-1:0] pend_idx_reg, pend_idx_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [31:0]   got_reg, got_next;

    logic          done_reg, done_next;
    logic [1:0]    status_reg, status_next;
    logic [6:0]    position_reg, position_next;
    logic [31:0]   found_reg, found_next;
    logic [7:0]    count_reg, count_next;

    logic [CW-1:0] fill_inc;
    logic [CW-1:0] fill_dec;
    logic [CW-1:0] idx_inc;
    logic [CW-1:0] idx_dec;
    logic [CW-1:0] pend_inc;
    logic          full;
    logic          hit;

    assign fill_inc = fill_reg + 1'b1;
    assign fill_dec = fill_reg - 1'b1;
    assign idx_inc  = idx_reg + 1'b1;
    assign idx_dec  = idx_reg - 1'b1;
    assign pend_inc = CW'(pend_idx_reg) + 1'b1;
    assign full     = (fill_reg == CW'(DEPTH));
    assign hit      = pend_reg && (rd_data.key == key_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            idx_reg   <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            idx_reg   <= idx_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        key_reg      <= key_next;
        val_reg      <= val_next;
        pend_idx_reg <= pend_idx_next;
        pos_reg      <= pos_next;
        got_reg      <= got_next;
        status_reg   <= status_next;
        position_reg <= position_next;
        found_reg    <= found_next;
        count_reg    <= count_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        req_next      = req_reg;
        key_next      = key_reg;
        val_next      = val_reg;
        fill_next     = fill_reg;
        idx_next      = idx_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        pos_next      = pos_reg;
        got_next      = got_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        position_next = position_reg;
        found_next    = found_reg;
        count_next    = count_reg;
        mem_ctl       = '0;
        rd_addr       = idx_reg[AW-1:0];
        wr_addr       = pend_idx_reg;
        wr_data       = rd_data;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next  = req_type;
                    key_next  = key;
                    val_next  = record_value;
                    idx_next  = '0;
                    pend_next = 1'b0;
                    priority if (req_type == REQ_INSERT && full)
                    begin
                        done_next     = 1'b1;
                        status_next   = ST_FULL;
                        position_next = '0;
                        found_next    = '0;
                        count_next    = 8'(fill_reg);
                    end
                    else if (req_type != REQ_INSERT && req_type != REQ_REMOVE
                             && req_type != REQ_FIND)
                    begin
                        done_next     = 1'b1;
                        status_next   = ST_OK;
                        position_next = '0;
                        found_next    = '0;
                        count_next    = 8'(fill_reg);
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // Compare the entry read last cycle while the next read goes out.
                priority if (hit)
                begin
                    pend_next = 1'b0;
                    priority if (req_reg == REQ_INSERT)
                    begin
                        done_next     = 1'b1;
                        status_next   = ST_DUP;
                        position_next = '0;
                        found_next    = '0;
                        count_next    = 8'(fill_reg);
                        state_next    = S_IDLE;
                    end
                    else if (req_reg == REQ_FIND)
                    begin
                        done_next     = 1'b1;
                        status_next   = ST_OK;
                        position_next = 7'(pend_idx_reg);
                        found_next    = rd_data.value;
                        count_next    = 8'(fill_reg);
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        pos_next   = pend_idx_reg;
                        got_next   = rd_data.value;
                        idx_next   = pend_inc;
                        state_next = S_SHIFT;
                    end
                end
                else if (idx_reg == fill_reg && !pend_reg)
                begin
                    done_next     = 1'b1;
                    position_next = '0;
                    found_next    = '0;
                    count_next    = 8'(fill_reg);
                    state_next    = S_IDLE;
                    if (req_reg == REQ_INSERT)
                    begin
                        // Append at the end of the table.
                        mem_ctl.wr_en = 1'b1;
                        wr_addr       = fill_reg[AW-1:0];
                        wr_data.key   = key_reg;
                        wr_data.value = val_reg;
                        fill_next     = fill_inc;
                        status_next   = ST_OK;
                        position_next = 7'(fill_reg);
                        count_next    = 8'(fill_inc);
                    end
                    else
                    begin
                        status_next = ST_MISS;
                    end
                end
                else if (idx_reg < fill_reg)
                begin
                    mem_ctl.rd_en = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg[AW-1:0];
                    idx_next      = idx_inc;
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end

            S_SHIFT:
            begin
                // Read entry i+1, write it back to i on the following cycle.
                if (pend_reg)
                begin
                    mem_ctl.wr_en = 1'b1;
                end
                if (idx_reg < fill_reg)
                begin
                    mem_ctl.rd_en = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = idx_dec[AW-1:0];
                    idx_next      = idx_inc;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        fill_next     = fill_dec;
                        done_next     = 1'b1;
                        status_next   = ST_OK;
                        position_next = 7'(pos_reg);
                        found_next    = got_reg;
                        count_next    = 8'(fill_dec);
                        state_next    = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign position    = position_reg;
    assign found_value = found_reg;
    assign entry_count = count_reg;

endmodule

`default_nettype wire

// ===== sv/unique_key_ordered_table.sv =====
// ----------------------------------------------------------------------------
// unique_key_ordered_table
// Ordered table of up to DEPTH key/value records with unique signed keys:
// insert appends, remove deletes the matching entry and closes the gap,
// find reports position and value.
//
//   Channel   Handshake         Fields
//   -------   ---------------   ------------------------------------------
//   request   start / busy      req_type, key, record_value
//   result    done (1 cycle)    status, position, found_value, entry_count
//
// A transaction is taken when start is high and busy is low. The result shows
// on done in the cycle after the operation finishes; done is never held off.
// Insert, find and a missed remove scan the stored entries through one memory
// read port and one key comparator. A remove that hits stops the scan at the
// match and shifts the later entries down one per cycle from there. Full and
// unused requests answer straight from idle, without a scan. Reset empties
// the table at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module unique_key_ordered_table #(
    parameter int DEPTH = ukot_pkg::DEPTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         req_type,
    input  wire logic signed [31:0] key,
    input  wire logic [31:0]        record_value,
    output logic                    done,
    output logic [1:0]              status,
    output logic [6:0]              position,
    output logic [31:0]             found_value,
    output logic [7:0]              entry_count
);
    import ukot_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    mem_ctl_t      mem_ctl;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;
    entry_t        rd_data;

    ukot_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .key          (key),
        .record_value (record_value),
        .mem_ctl      (mem_ctl),
        .rd_addr      (rd_addr),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .rd_data      (rd_data),
        .done         (done),
        .status       (status),
        .position     (position),
        .found_value  (found_value),
        .entry_count  (entry_count)
    );

    ukot_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .ctl     (mem_ctl),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

endmodule

`default_nettype wire

// ===== sv/ukot_checker.sv =====
// ----------------------------------------------------------------------------
// ukot_checker
// Port-level checks for the ordered table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ukot_checker #(
    parameter int DEPTH = ukot_pkg::DEPTH_DEF
) (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic               done,
    input wire logic [1:0]         status,
    input wire logic [6:0]         position,
    input wire logic [31:0]        found_value,
    input wire logic [7:0]         entry_count
);
    import ukot_pkg::*;

    // An accepted transaction either starts work or answers right away.
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted transaction neither busy nor answered");

    // A result only appears once the sequencer is free again.
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // Every refusal carries zero position and value.
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (position == 7'd0 && found_value == 32'd0))
        else $error("error result with nonzero payload");

    // Full is only reported with a full table.
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_FULL) |-> (entry_count == 8'(DEPTH)))
        else $error("full status with table not full");

endmodule

bind unique_key_ordered_table ukot_checker #(.DEPTH(DEPTH)) u_ukot_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .status       (status),
    .position     (position),
    .found_value  (found_value),
    .entry_count  (entry_count)
);

`default_nettype wire
